### rtl/twled_pkg.sv
// shared types and protocol constants for the two-wire led display frame sender
package twled_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_DATA  = 3'd2,
        PH_CLKHI = 3'd3,
        PH_CLKLO = 3'd4,
        PH_STOP  = 3'd5
    } phase_t;

    localparam logic [7:0] CMD_DATA     = 8'h40;
    localparam logic [7:0] CMD_ADDR     = 8'hC0;
    localparam logic [7:0] CMD_DISP_ON  = 8'h88;
    localparam logic [7:0] CMD_DISP_OFF = 8'h80;

    localparam logic       KIND_TICK    = 1'b0;
    localparam logic       KIND_REQUEST = 1'b1;

    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_DISPLAY_ON = 2'd1;

    localparam logic [3:0] ACK_SLOT  = 4'd8;
    localparam logic [2:0] LAST_DIGIT = 3'd4;
    localparam logic [1:0] TX_DATA   = 2'd0;
    localparam logic [1:0] TX_ADDR   = 2'd1;
    localparam logic [1:0] TX_CTRL   = 2'd2;

endpackage

### rtl/two_wire_led_display_frame_sender.sv
// Frame sender for a two-wire (clock/data) seven-segment led display controller.
// A request word (tuser = 1) while idle latches four digit bytes from tdata and starts
// a frame of three transactions: data command, address plus four digits, control byte.
// Every tick word (tuser = 0) in a frame moves the clock or data line by one level change;
// start, each bit, the unsampled ack slot and stop take fixed tick sequences. Each input
// word yields one result word holding line levels and busy flag, tlast marking the tick that
// completes the final stop. One word is taken per clock cycle: the line state is updated
// in the same cycle the word is accepted and the result goes to an output register, so
// throughput is bounded only by the output handshake (a new word enters whenever the
// output register is empty or being drained). Configuration writes are always accepted.
module two_wire_led_display_frame_sender
    import twled_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // digit0_segments, digit1, digit2, digit3_segments
    input  logic        s_axis_tuser,   // kind
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // clock_line, data_line, busy_res, zero pad
    output logic        m_axis_tlast,   // frame_done
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data
);

    logic [2:0] brightness_reg;
    logic       display_on_reg;

    logic [1:0] tx_reg,     tx_next;
    logic [2:0] byte_reg,   byte_next;
    logic [3:0] bit_reg,    bit_next;
    phase_t     phase_reg,  phase_next;
    logic [7:0] shift_reg,  shift_next;
    logic       clk_reg,    clk_next;
    logic       dio_reg,    dio_next;
    logic       busy_reg,   busy_next;
    logic       done_next;
    logic       digit_we;

    logic [7:0] digit_mem [4];

    logic       out_valid_reg;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_last_reg;

    logic       in_accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    function automatic logic [7:0] pick_byte(input logic [1:0] tx, input logic [2:0] bidx,
                                             input logic [7:0] dig,
                                             input logic       on, input logic [2:0] br);
        logic [7:0] b;
        if (tx == TX_DATA) begin
            b = CMD_DATA;
        end else if (tx == TX_ADDR) begin
            b = (bidx == 3'd0) ? CMD_ADDR : dig;
        end else if (on) begin
            b = CMD_DISP_ON | {5'd0, br};
        end else begin
            b = CMD_DISP_OFF;
        end
        return b;
    endfunction

    // digits for the current byte (byte_index - 1 addresses the store) and for the byte after it
    logic [7:0] digit_rd_cur, digit_rd_inc;
    logic [2:0] byte_dec_cur;
    assign byte_dec_cur = byte_reg - 3'd1;
    assign digit_rd_cur = digit_mem[byte_dec_cur[1:0]];
    assign digit_rd_inc = digit_mem[byte_reg[1:0]];

    // next state
    always_comb begin
        tx_next    = tx_reg;
        byte_next  = byte_reg;
        bit_next   = bit_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        clk_next   = clk_reg;
        dio_next   = dio_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        digit_we   = 1'b0;
        if (s_axis_tuser == KIND_REQUEST) begin
            if (!busy_reg) begin
                digit_we   = 1'b1;
                tx_next    = TX_DATA;
                byte_next  = 3'd0;
                bit_next   = 4'd0;
                phase_next = PH_START;
                busy_next  = 1'b1;
            end
        end else if (busy_reg) begin
            case (phase_reg)
                PH_START: begin
                    if (bit_reg == 4'd0) begin
                        dio_next = 1'b0;
                        bit_next = 4'd1;
                    end else begin
                        clk_next   = 1'b0;
                        bit_next   = 4'd0;
                        shift_next = pick_byte(tx_reg, byte_reg, digit_rd_cur,
                                               display_on_reg, brightness_reg);
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    dio_next   = (bit_reg >= ACK_SLOT) ? 1'b1 : shift_reg[0];
                    phase_next = PH_CLKHI;
                end
                PH_CLKHI: begin
                    clk_next   = 1'b1;
                    phase_next = PH_CLKLO;
                end
                PH_CLKLO: begin
                    clk_next = 1'b0;
                    if (bit_reg < ACK_SLOT) begin
                        shift_next = {1'b0, shift_reg[7:1]};
                        bit_next   = bit_reg + 4'd1;
                        phase_next = PH_DATA;
                    end else if (tx_reg == TX_ADDR && byte_reg < LAST_DIGIT) begin
                        byte_next  = byte_reg + 3'd1;
                        bit_next   = 4'd0;
                        shift_next = pick_byte(tx_reg, byte_reg + 3'd1, digit_rd_inc,
                                               display_on_reg, brightness_reg);
                        phase_next = PH_DATA;
                    end else begin
                        bit_next   = 4'd0;
                        phase_next = PH_STOP;
                    end
                end
                PH_STOP: begin
                    if (bit_reg == 4'd0) begin
                        dio_next = 1'b0;
                        bit_next = 4'd1;
                    end else if (bit_reg == 4'd1) begin
                        clk_next = 1'b1;
                        bit_next = 4'd2;
                    end else begin
                        dio_next  = 1'b1;
                        bit_next  = 4'd0;
                        byte_next = 3'd0;
                        if (tx_reg >= TX_CTRL) begin
                            tx_next    = TX_DATA;
                            phase_next = PH_IDLE;
                            busy_next  = 1'b0;
                            done_next  = 1'b1;
                        end else begin
                            tx_next    = tx_reg + 2'd1;
                            phase_next = PH_START;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result word
    always_comb begin
        out_data_next = {5'd0, busy_next, dio_next, clk_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= 3'd7;
            display_on_reg <= 1'b1;
            tx_reg         <= TX_DATA;
            byte_reg       <= 3'd0;
            bit_reg        <= 4'd0;
            phase_reg      <= PH_IDLE;
            shift_reg      <= 8'd0;
            clk_reg        <= 1'b1;
            dio_reg        <= 1'b1;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BRIGHTNESS: brightness_reg <= cfg_data;
                    REG_DISPLAY_ON: display_on_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                tx_reg        <= tx_next;
                byte_reg      <= byte_next;
                bit_reg       <= bit_next;
                phase_reg     <= phase_next;
                shift_reg     <= shift_next;
                clk_reg       <= clk_next;
                dio_reg       <= dio_next;
                busy_reg      <= busy_next;
                out_valid_reg <= 1'b1;
                out_last_reg  <= done_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_data_reg <= out_data_next;
        end
        if (in_accept && digit_we) begin
            digit_mem[0] <= s_axis_tdata[7:0];
            digit_mem[1] <= s_axis_tdata[15:8];
            digit_mem[2] <= s_axis_tdata[23:16];
            digit_mem[3] <= s_axis_tdata[31:24];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### rtl/twled_checker.sv
// port-level checks for the two-wire led display frame sender
module twled_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [2:0]  cfg_data
);

    // completion word already shows the frame as finished
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[2])
        else $error("frame_done with busy set");

    // a stalled result blocks new input words
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while result stalled");

    // result register empties on reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // stalled result word holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind two_wire_led_display_frame_sender twled_checker u_twled_checker (.*);
